FILE: design/wbm_pkg.sv
// Shared widths, codes and types for the windowed bitrate meter.
`default_nettype none

package wbm_pkg;

  // Fraction bits of the published rate
  localparam int FRAC_BITS = 16;

  localparam int FUNC_W  = 2;
  localparam int TOTAL_W = 32;
  localparam int TICK_W  = 32;
  localparam int TRATE_W = 20;
  localparam int RATE_W  = 47;
  localparam int PROD_W  = TOTAL_W + TRATE_W;
  localparam int NUM_W   = PROD_W + FRAC_BITS;
  localparam int DCNT_W  = $clog2(NUM_W + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = 1'b1;
  localparam logic [TRATE_W-1:0]   TICK_RATE_RESET = TRATE_W'(1000);

  // Input function codes
  localparam logic [FUNC_W-1:0] FUNC_ADD_BITS  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD_BYTES = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESTART   = 2'd2;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ADD,
    OP_RESTART,
    OP_NOP
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [TOTAL_W-1:0]  add;
    logic [TICK_W-1:0]   now;
  } op_t;

endpackage

`default_nettype wire

FILE: design/wbm_in_if.sv
// Input channel interface: valid/ready plus one input transaction.
`default_nettype none

interface wbm_in_if import wbm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [TOTAL_W-1:0]  amount;
  logic [TICK_W-1:0]   now_ticks;

  modport source (output valid, func, amount, now_ticks, input ready);
  modport sink   (input valid, func, amount, now_ticks, output ready);
endinterface

`default_nettype wire

FILE: design/wbm_out_if.sv
// Result channel interface: valid/ready plus one result transaction.
`default_nettype none

interface wbm_out_if import wbm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                updated;
  logic [RATE_W-1:0]   bitrate;
  logic [RATE_W-1:0]   max_bitrate;
  logic [RATE_W-1:0]   min_bitrate;
  logic                have_min;
  logic [TOTAL_W-1:0]  bit_total;

  modport source (output valid, updated, bitrate, max_bitrate, min_bitrate, have_min,
                  bit_total, input ready);
  modport sink   (input valid, updated, bitrate, max_bitrate, min_bitrate, have_min,
                  bit_total, output ready);
endinterface

`default_nettype wire

FILE: design/windowed_bitrate_meter_unit.sv
// Windowed bitrate meter top level: config registers, front, queue, back and divider.
// An add that publishes nothing passes the front register, the queue, the back stage's idle
// and check states and then the result register; a restart or a no-op skips the check state.
// When the rate gate opens, the add goes on through the multiply state, the bit-serial divider
// that produces one quotient bit per cycle, the wait state and the update state. The back stage
// takes a new operation only from its idle state; the front register and a two-entry queue keep
// accepting transactions while the back stage or the result side stalls, until they fill.
// Reset: synchronous active-low rst_n clears all meter state, empties the queue and loads
// threshold 0 and tick rate 1000.
`default_nettype none

module windowed_bitrate_meter_unit import wbm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  wbm_in_if.sink                in_ch,
  wbm_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers; write them only while the meter is idle
  logic [TOTAL_W-1:0] threshold_r;
  logic [TRATE_W-1:0] tick_rate_r;

  // Front to queue
  logic q_push;
  op_t  q_push_data;
  logic q_full;

  // Queue to back
  logic q_pop;
  op_t  q_pop_data;
  logic q_valid;

  // Back to divider
  logic              div_start;
  logic [NUM_W-1:0]  div_numer;
  logic [TICK_W-1:0] div_denom;
  logic              div_done;
  logic [RATE_W-1:0] div_quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
      tick_rate_r <= TICK_RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: threshold_r <= cfg_wdata[TOTAL_W-1:0];
        CFG_TICK_RATE: tick_rate_r <= cfg_wdata[TRATE_W-1:0];
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  // Accept and classify each input transaction
  wbm_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_push (q_push),
    .q_data (q_push_data),
    .q_full (q_full)
  );

  // Decouple the front from the slow back stage
  wbm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .not_empty (q_valid)
  );

  // Rate divider: (bits * tick_rate << FRAC_BITS) / delta
  wbm_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .numer    (div_numer),
    .denom    (div_denom),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Meter state, gate and result register
  wbm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .threshold_bits (threshold_r),
    .tick_rate      (tick_rate_r),
    .q_valid        (q_valid),
    .q_data         (q_pop_data),
    .q_pop          (q_pop),
    .div_start      (div_start),
    .div_numer      (div_numer),
    .div_denom      (div_denom),
    .div_done       (div_done),
    .div_quo        (div_quo),
    .out_ch         (out_ch)
  );

endmodule

`default_nettype wire

FILE: design/wbm_front.sv
// Front stage: accept input transactions and classify them into operations.
`default_nettype none

module wbm_front import wbm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  wbm_in_if.sink in_ch,
  output logic q_push,
  output op_t  q_data,
  input  logic q_full
);

  logic stage_valid_r, stage_valid_nxt;
  op_t  stage_r, stage_nxt;
  logic accept;

  assign q_push      = stage_valid_r && !q_full;
  assign q_data      = stage_r;
  assign in_ch.ready = !stage_valid_r || !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    stage_nxt       = stage_r;
    if (q_push) begin
      stage_valid_nxt = 1'b0;
    end
    if (accept) begin
      stage_valid_nxt = 1'b1;
      stage_nxt.now   = in_ch.now_ticks;
      stage_nxt.add   = in_ch.amount;
      case (in_ch.func)
        FUNC_ADD_BITS: begin
          stage_nxt.kind = OP_ADD;
        end
        FUNC_ADD_BYTES: begin
          stage_nxt.kind = OP_ADD;
          stage_nxt.add  = in_ch.amount << 3;
        end
        FUNC_RESTART: begin
          stage_nxt.kind = OP_RESTART;
        end
        default: begin
          stage_nxt.kind = OP_NOP;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
    stage_r <= stage_nxt;
  end

endmodule

`default_nettype wire

FILE: design/wbm_queue.sv
// Short operation queue between the front and back stages.
`default_nettype none

module wbm_queue import wbm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_data,
  output logic full,
  input  logic pop,
  output op_t  pop_data,
  output logic not_empty
);

  op_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: design/wbm_divider.sv
// Restoring divider, one quotient bit per cycle, with 47-bit saturation.
`default_nettype none

module wbm_divider import wbm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [NUM_W-1:0]   numer,
  input  logic [TICK_W-1:0]  denom,
  output logic               done,
  output logic [RATE_W-1:0]  quotient
);

  logic [TICK_W-1:0] rem_r;
  logic [TICK_W-1:0] den_r;
  logic [NUM_W-1:0]  quo_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [TICK_W:0]   shifted;
  logic              fits;

  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign fits    = (shifted >= {1'b0, den_r});
  assign done    = done_r;
  // Saturate when anything lands above the result width
  assign quotient = (quo_r[NUM_W-1:RATE_W] != '0) ? '1 : quo_r[RATE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DCNT_W'(1);
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      rem_r <= '0;
      den_r <= denom;
      quo_r <= numer;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= TICK_W'(shifted - {1'b0, den_r});
        quo_r <= {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[TICK_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/wbm_back.sv
// Back stage: meter state, rate gate, multiply, divide hand-off and result register.
`default_nettype none

module wbm_back import wbm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [TOTAL_W-1:0] threshold_bits,
  input  logic [TRATE_W-1:0] tick_rate,
  input  logic               q_valid,
  input  op_t                q_data,
  output logic               q_pop,
  output logic               div_start,
  output logic [NUM_W-1:0]   div_numer,
  output logic [TICK_W-1:0]  div_denom,
  input  logic               div_done,
  input  logic [RATE_W-1:0]  div_quo,
  wbm_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_WAIT,
    S_UPD
  } state_t;

  state_t             state_r, state_nxt;
  logic [TOTAL_W-1:0] bit_total_r, bit_total_nxt;
  logic [TICK_W-1:0]  window_start_r, window_start_nxt;
  logic [RATE_W-1:0]  last_rate_r, last_rate_nxt;
  logic [RATE_W-1:0]  peak_rate_r, peak_rate_nxt;
  logic [RATE_W-1:0]  floor_rate_r, floor_rate_nxt;
  logic               floor_valid_r, floor_valid_nxt;
  logic [TICK_W-1:0]  now_r, now_nxt;
  logic [TICK_W-1:0]  delta_r, delta_nxt;
  logic               delta_ok_r, delta_ok_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               updated_r, updated_nxt;

  logic [TRATE_W-1:0] rate_eff;
  logic               out_free;
  logic               gate;

  assign rate_eff = (tick_rate == '0) ? TRATE_W'(1) : tick_rate;
  assign out_free = !out_valid_r || out_ch.ready;
  assign gate     = (bit_total_r >= threshold_bits) && delta_ok_r &&
                    (delta_r >= {{(TICK_W-TRATE_W-1){1'b0}}, rate_eff, 1'b0});

  assign div_numer = NUM_W'(prod_r) << FRAC_BITS;
  assign div_denom = delta_r;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.updated     = updated_r;
  assign out_ch.bitrate     = last_rate_r;
  assign out_ch.max_bitrate = peak_rate_r;
  assign out_ch.min_bitrate = floor_rate_r;
  assign out_ch.have_min    = floor_valid_r;
  assign out_ch.bit_total   = bit_total_r;

  always_comb begin
    state_nxt        = state_r;
    bit_total_nxt    = bit_total_r;
    window_start_nxt = window_start_r;
    last_rate_nxt    = last_rate_r;
    peak_rate_nxt    = peak_rate_r;
    floor_rate_nxt   = floor_rate_r;
    floor_valid_nxt  = floor_valid_r;
    now_nxt          = now_r;
    delta_nxt        = delta_r;
    delta_ok_nxt     = delta_ok_r;
    prod_nxt         = prod_r;
    out_valid_nxt    = out_valid_r;
    updated_nxt      = updated_r;
    q_pop            = 1'b0;
    div_start        = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (q_data.kind)
            OP_RESTART: begin
              bit_total_nxt    = '0;
              window_start_nxt = q_data.now;
              updated_nxt      = 1'b0;
              out_valid_nxt    = 1'b1;
            end
            OP_ADD: begin
              bit_total_nxt = bit_total_r + q_data.add;
              now_nxt       = q_data.now;
              delta_nxt     = q_data.now - window_start_r;
              delta_ok_nxt  = (q_data.now >= window_start_r);
              state_nxt     = S_CHECK;
            end
            default: begin
              updated_nxt   = 1'b0;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_CHECK: begin
        if (gate) begin
          prod_nxt  = PROD_W'(bit_total_r) * PROD_W'(rate_eff);
          state_nxt = S_MUL;
        end else begin
          updated_nxt   = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_MUL: begin
        div_start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          last_rate_nxt = div_quo;
          state_nxt     = S_UPD;
        end
      end
      S_UPD: begin
        if (last_rate_r > peak_rate_r) begin
          peak_rate_nxt = last_rate_r;
        end
        if (!floor_valid_r || last_rate_r < floor_rate_r) begin
          floor_rate_nxt = last_rate_r;
        end
        floor_valid_nxt  = 1'b1;
        bit_total_nxt    = '0;
        window_start_nxt = now_r;
        updated_nxt      = 1'b1;
        out_valid_nxt    = 1'b1;
        state_nxt        = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      bit_total_r    <= '0;
      window_start_r <= '0;
      last_rate_r    <= '0;
      peak_rate_r    <= '0;
      floor_rate_r   <= '0;
      floor_valid_r  <= 1'b0;
      out_valid_r    <= 1'b0;
      updated_r      <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      bit_total_r    <= bit_total_nxt;
      window_start_r <= window_start_nxt;
      last_rate_r    <= last_rate_nxt;
      peak_rate_r    <= peak_rate_nxt;
      floor_rate_r   <= floor_rate_nxt;
      floor_valid_r  <= floor_valid_nxt;
      out_valid_r    <= out_valid_nxt;
      updated_r      <= updated_nxt;
    end
    now_r      <= now_nxt;
    delta_r    <= delta_nxt;
    delta_ok_r <= delta_ok_nxt;
    prod_r     <= prod_nxt;
  end

endmodule

`default_nettype wire
